@@ design/gcac_pkg.sv @@
// shared types, register codes and constants of the grow climate actuator controller
package gcac_pkg;

    // configuration write channel
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WATER_LIMIT     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WATERING_MS     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUNNY_HOURS     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LUX_THRESH      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDEAL_AIR_TEMP  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDEAL_HUMIDITY  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IDEAL_SOIL_TEMP = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_BAND       = 4'd7;

    // register reset values
    localparam logic [6:0]         RST_WATER_LIMIT     = 7'd30;
    localparam logic [15:0]        RST_WATERING_MS     = 16'd2000;
    localparam logic [4:0]         RST_SUNNY_HOURS     = 5'd12;
    localparam logic [15:0]        RST_LUX_THRESH      = 16'd1000;
    localparam logic signed [10:0] RST_IDEAL_AIR_TEMP  = 11'sd220;
    localparam logic [9:0]         RST_IDEAL_HUMIDITY  = 10'd600;
    localparam logic signed [10:0] RST_IDEAL_SOIL_TEMP = 11'sd200;
    localparam logic [7:0]         RST_TEMP_BAND       = 8'd20;

    // fixed constants of the rules
    localparam int LIGHT_NOON = 12;
    localparam int MS_PER_S   = 1000;

    // actuator slots of the last-toggle table
    localparam logic [1:0] ACT_PUMP  = 2'd0;
    localparam logic [1:0] ACT_LIGHT = 2'd1;
    localparam logic [1:0] ACT_FAN   = 2'd2;
    localparam logic [1:0] ACT_PAD   = 2'd3;
    localparam int         ACT_NUM   = 4;

    typedef struct packed {
        logic [6:0]         water_limit;
        logic [15:0]        watering_ms;
        logic [4:0]         sunny_hours;
        logic [15:0]        lux_thresh;
        logic signed [10:0] ideal_air_temp;
        logic [9:0]         ideal_humidity;
        logic signed [10:0] ideal_soil_temp;
        logic [7:0]         temp_band;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic [4:0]         hour_of_day;
        logic [6:0]         soil_moisture;
        logic [15:0]        light_lux;
        logic signed [10:0] air_temp;
        logic [9:0]         air_humidity;
        logic signed [10:0] soil_temp;
    } sample_t;

    typedef struct packed {
        logic pump;
        logic light;
        logic fan;
        logic pad;
    } drive_t;

endpackage

@@ design/gcac_channels.sv @@
// valid/ready channel interfaces for samples, results and configuration writes
interface gcac_sample_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic [4:0]         hour_of_day;
    logic [6:0]         soil_moisture;
    logic [15:0]        light_lux;
    logic signed [10:0] air_temp;
    logic [9:0]         air_humidity;
    logic signed [10:0] soil_temp;

    modport source (
        output valid, now_ms, hour_of_day, soil_moisture, light_lux,
               air_temp, air_humidity, soil_temp,
        input  ready
    );
    modport sink (
        input  valid, now_ms, hour_of_day, soil_moisture, light_lux,
               air_temp, air_humidity, soil_temp,
        output ready
    );
endinterface

interface gcac_result_if;
    logic valid;
    logic ready;
    logic pump_drive;
    logic light_drive;
    logic fan_drive;
    logic pad_drive;

    modport source (
        output valid, pump_drive, light_drive, fan_drive, pad_drive,
        input  ready
    );
    modport sink (
        input  valid, pump_drive, light_drive, fan_drive, pad_drive,
        output ready
    );
endinterface

interface gcac_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ design/gcac_cfg_regs.sv @@
// configuration register file fed by the write channel
module gcac_cfg_regs (
    input  logic         clk,
    input  logic         rst_n,
    gcac_cfg_if.sink     cfg,
    output gcac_pkg::cfg_t regs
);
    import gcac_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WATER_LIMIT:     regs_next.water_limit     = cfg.data[6:0];
                REG_WATERING_MS:     regs_next.watering_ms     = cfg.data;
                REG_SUNNY_HOURS:     regs_next.sunny_hours     = cfg.data[4:0];
                REG_LUX_THRESH:      regs_next.lux_thresh      = cfg.data;
                REG_IDEAL_AIR_TEMP:  regs_next.ideal_air_temp  = $signed(cfg.data[10:0]);
                REG_IDEAL_HUMIDITY:  regs_next.ideal_humidity  = cfg.data[9:0];
                REG_IDEAL_SOIL_TEMP: regs_next.ideal_soil_temp = $signed(cfg.data[10:0]);
                REG_TEMP_BAND:       regs_next.temp_band       = cfg.data[7:0];
                default:             regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.water_limit     <= RST_WATER_LIMIT;
            regs_reg.watering_ms     <= RST_WATERING_MS;
            regs_reg.sunny_hours     <= RST_SUNNY_HOURS;
            regs_reg.lux_thresh      <= RST_LUX_THRESH;
            regs_reg.ideal_air_temp  <= RST_IDEAL_AIR_TEMP;
            regs_reg.ideal_humidity  <= RST_IDEAL_HUMIDITY;
            regs_reg.ideal_soil_temp <= RST_IDEAL_SOIL_TEMP;
            regs_reg.temp_band       <= RST_TEMP_BAND;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ design/gcac_rules.sv @@
// actuator state and the per-sample switching rules
module gcac_rules #(
    parameter int PUMP_WAIT_S   = 60,
    parameter int LIGHT_WAIT_S  = 60,
    parameter int FAN_WAIT_S    = 60,
    parameter int PAD_WAIT_S    = 60,
    parameter int HUMIDITY_BAND = 50
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gcac_pkg::cfg_t    cfg,
    input  gcac_pkg::sample_t smp,
    input  logic              step,
    output gcac_pkg::drive_t  drive_next
);
    import gcac_pkg::*;

    localparam logic [31:0] PUMP_WAIT_MS  = 32'(PUMP_WAIT_S * MS_PER_S);
    localparam logic [31:0] LIGHT_WAIT_MS = 32'(LIGHT_WAIT_S * MS_PER_S);
    localparam logic [31:0] FAN_WAIT_MS   = 32'(FAN_WAIT_S * MS_PER_S);
    localparam logic [31:0] PAD_WAIT_MS   = 32'(PAD_WAIT_S * MS_PER_S);
    localparam logic [11:0] HUM_BAND      = 12'(HUMIDITY_BAND);
    localparam logic signed [6:0] NOON    = 7'(LIGHT_NOON);

    drive_t      on_reg;
    drive_t      on_next;
    logic [31:0] run_start_reg;
    logic [31:0] last_toggle_reg [ACT_NUM];

    // wait checks, differences wrap
    logic [31:0] pump_waited, light_waited, fan_waited, pad_waited, run_time;
    logic        pump_can, light_can, fan_can, pad_can;

    logic        want_water, light_enough, sunny;
    logic signed [6:0]  win_start, win_end, hour_s;
    logic signed [12:0] band_s, air_s, soil_s, ideal_air_s, ideal_soil_s;
    logic               air_hot, air_cold, soil_hot, soil_cold, humid, dry_enough;
    logic               pump_tgl, light_tgl, fan_tgl, pad_tgl;

    always_comb
    begin
        pump_waited  = smp.now_ms - last_toggle_reg[ACT_PUMP];
        light_waited = smp.now_ms - last_toggle_reg[ACT_LIGHT];
        fan_waited   = smp.now_ms - last_toggle_reg[ACT_FAN];
        pad_waited   = smp.now_ms - last_toggle_reg[ACT_PAD];
        run_time     = smp.now_ms - run_start_reg;
        pump_can     = pump_waited >= PUMP_WAIT_MS;
        light_can    = light_waited >= LIGHT_WAIT_MS;
        fan_can      = fan_waited >= FAN_WAIT_MS;
        pad_can      = pad_waited >= PAD_WAIT_MS;

        // pump: timed run or soil wet enough stops it
        want_water = smp.soil_moisture < cfg.water_limit;
        pump_tgl   = on_reg.pump
                   ? ((run_time >= {16'd0, cfg.watering_ms}) || !want_water)
                   : (want_water && pump_can);

        // light: window centered on noon, may start below zero
        win_start    = NOON - $signed({3'b000, cfg.sunny_hours[4:1]});
        win_end      = win_start + $signed({2'b00, cfg.sunny_hours});
        hour_s       = $signed({2'b00, smp.hour_of_day});
        sunny        = (hour_s >= win_start) && (hour_s < win_end);
        light_enough = smp.light_lux > cfg.lux_thresh;
        light_tgl    = on_reg.light
                     ? ((light_enough && light_can) || !sunny)
                     : (!light_enough && sunny && light_can);

        // fan and pad temperature bands
        band_s       = $signed({5'b00000, cfg.temp_band});
        air_s        = $signed({{2{smp.air_temp[10]}}, smp.air_temp});
        soil_s       = $signed({{2{smp.soil_temp[10]}}, smp.soil_temp});
        ideal_air_s  = $signed({{2{cfg.ideal_air_temp[10]}}, cfg.ideal_air_temp});
        ideal_soil_s = $signed({{2{cfg.ideal_soil_temp[10]}}, cfg.ideal_soil_temp});
        air_hot      = air_s > (ideal_air_s + band_s);
        air_cold     = air_s < (ideal_air_s - band_s);
        soil_hot     = soil_s > (ideal_soil_s + band_s);
        soil_cold    = soil_s < (ideal_soil_s - band_s);
        humid        = {2'b00, smp.air_humidity} > ({2'b00, cfg.ideal_humidity} + HUM_BAND);
        dry_enough   = smp.air_humidity <= cfg.ideal_humidity;

        fan_tgl = fan_can && (on_reg.fan ? (air_cold && dry_enough) : (air_hot || humid));
        pad_tgl = pad_can && (on_reg.pad ? soil_hot : soil_cold);

        on_next.pump  = on_reg.pump ^ pump_tgl;
        on_next.light = on_reg.light ^ light_tgl;
        on_next.fan   = on_reg.fan ^ fan_tgl;
        on_next.pad   = on_reg.pad ^ pad_tgl;
    end

    assign drive_next = on_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg        <= '0;
            run_start_reg <= '0;
            for (int i = 0; i < ACT_NUM; i++)
            begin
                last_toggle_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            on_reg <= on_next;
            if (pump_tgl)
            begin
                last_toggle_reg[ACT_PUMP] <= smp.now_ms;
                if (!on_reg.pump)
                begin
                    run_start_reg <= smp.now_ms;
                end
            end
            if (light_tgl)
            begin
                last_toggle_reg[ACT_LIGHT] <= smp.now_ms;
            end
            if (fan_tgl)
            begin
                last_toggle_reg[ACT_FAN] <= smp.now_ms;
            end
            if (pad_tgl)
            begin
                last_toggle_reg[ACT_PAD] <= smp.now_ms;
            end
        end
    end

endmodule

@@ design/grow_climate_actuator_controller.sv @@
// top level of the grow climate actuator controller
// One sample word per clock, back to back, as long as the result side keeps
// taking results: a sample is captured in an input register, the rules settle
// combinationally against the actuator state, and the four drive flags land in
// a result register, whose valid rises when the held sample moves on. The
// actuator state registers update once for each sample that moves on.
// The result register and the input register act as a skid pair, so a new
// sample is still taken while a finished result waits to be taken; sample
// ready drops only when both registers are full and the result is stalled.
// Configuration writes are always taken (cfg ready tied high) and should be
// issued only while no sample is in flight. Unknown register indexes are
// ignored. No clearing pass after reset.
module grow_climate_actuator_controller #(
    parameter int PUMP_WAIT_S   = 60,
    parameter int LIGHT_WAIT_S  = 60,
    parameter int FAN_WAIT_S    = 60,
    parameter int PAD_WAIT_S    = 60,
    parameter int HUMIDITY_BAND = 50
) (
    input  logic           clk,
    input  logic           rst_n,
    gcac_sample_if.sink    sample,
    gcac_result_if.source  result,
    gcac_cfg_if.sink       cfg
);
    import gcac_pkg::*;

    // configuration registers
    cfg_t    cfg_regs;

    // input stage
    logic    in_valid_reg;
    logic    in_valid_next;
    sample_t in_word_reg;
    logic    in_fire;
    logic    step;

    // result stage
    logic    res_valid_reg;
    logic    res_valid_next;
    drive_t  drive_reg;
    drive_t  drive_next;

    gcac_cfg_regs u_cfg_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (cfg_regs)
    );

    gcac_rules #(
        .PUMP_WAIT_S  (PUMP_WAIT_S),
        .LIGHT_WAIT_S (LIGHT_WAIT_S),
        .FAN_WAIT_S   (FAN_WAIT_S),
        .PAD_WAIT_S   (PAD_WAIT_S),
        .HUMIDITY_BAND(HUMIDITY_BAND)
    ) u_rules (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_regs),
        .smp       (in_word_reg),
        .step      (step),
        .drive_next(drive_next)
    );

    // the held sample moves on whenever the result register is free or draining
    assign step         = in_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || step;
    assign in_fire      = sample.valid && sample.ready;

    always_comb
    begin
        in_valid_next = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_reg);
        if (step)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_word_reg.now_ms        <= sample.now_ms;
            in_word_reg.hour_of_day   <= sample.hour_of_day;
            in_word_reg.soil_moisture <= sample.soil_moisture;
            in_word_reg.light_lux     <= sample.light_lux;
            in_word_reg.air_temp      <= sample.air_temp;
            in_word_reg.air_humidity  <= sample.air_humidity;
            in_word_reg.soil_temp     <= sample.soil_temp;
        end
        if (step)
        begin
            drive_reg <= drive_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.pump_drive  = drive_reg.pump;
    assign result.light_drive = drive_reg.light;
    assign result.fan_drive   = drive_reg.fan;
    assign result.pad_drive   = drive_reg.pad;

endmodule

@@ design/gcac_checker.sv @@
// port-level assertions for the controller and their bind
module gcac_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic res_valid,
    input logic res_ready,
    input logic pump_drive,
    input logic light_drive,
    input logic fan_drive,
    input logic pad_drive
);

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid
            && $stable({pump_drive, light_drive, fan_drive, pad_drive})))
        else $error("stalled result word changed");

    // sample side stalls only when both stages are full and the result is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (res_valid && !res_ready))
        else $error("sample ready dropped without a stalled result");

    // an accepted word reaches the result register once it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire ##1 !res_valid |=> res_valid)
        else $error("accepted word did not reach the result register");

    // no result right after reset release
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

endmodule

bind grow_climate_actuator_controller gcac_checker u_gcac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .pump_drive (result.pump_drive),
    .light_drive(result.light_drive),
    .fan_drive  (result.fan_drive),
    .pad_drive  (result.pad_drive)
);

@@ sim/grow_climate_actuator_controller_test.sv @@
// self-checking testbench of the grow climate actuator controller
`timescale 1ns / 1ps

module grow_climate_actuator_controller_test;
    import gcac_pkg::*;

    // rule parameters, handed to the block so both sides agree
    localparam int PUMP_WAIT_S   = 60;
    localparam int LIGHT_WAIT_S  = 60;
    localparam int FAN_WAIT_S    = 60;
    localparam int PAD_WAIT_S    = 60;
    localparam int HUMIDITY_BAND = 50;

    localparam logic [31:0] PUMP_HOLD_MS  = PUMP_WAIT_S * MS_PER_S;
    localparam logic [31:0] LIGHT_HOLD_MS = LIGHT_WAIT_S * MS_PER_S;
    localparam logic [31:0] FAN_HOLD_MS   = FAN_WAIT_S * MS_PER_S;
    localparam logic [31:0] PAD_HOLD_MS   = PAD_WAIT_S * MS_PER_S;

    // first register index the block does not decode
    localparam int REG_SPARE_LO    = 8;
    localparam int SAMPLES_PER_SET = 86;
    localparam int DRAIN_CYCLES    = 6;
    localparam int MAX_REPORTS     = 40;
    localparam int TIMEOUT_NS      = 3_000_000;

    typedef enum {SET_DEFAULT, SET_LOW, SET_HIGH, SET_RANDOM} setting_kind_t;
    typedef enum {TAKE_ALL, TAKE_HALF, TAKE_FEW} sink_mode_t;

    // one directed sample, with a hand-written answer where it is obvious
    typedef struct {
        sample_t smp;
        bit      typed;
        drive_t  want;
    } probe_t;

    logic clk;
    logic rst_n;

    gcac_sample_if sample_ch ();
    gcac_result_if result_ch ();
    gcac_cfg_if    cfg_ch ();

    grow_climate_actuator_controller #(
        .PUMP_WAIT_S   (PUMP_WAIT_S),
        .LIGHT_WAIT_S  (LIGHT_WAIT_S),
        .FAN_WAIT_S    (FAN_WAIT_S),
        .PAD_WAIT_S    (PAD_WAIT_S),
        .HUMIDITY_BAND (HUMIDITY_BAND)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // shadow of the block: register settings and actuator state
    cfg_t        settings;
    drive_t      actuators_on;
    logic [31:0] pump_started;
    logic [31:0] toggled_at [ACT_NUM];

    // drive words still owed by the block, oldest first
    drive_t drives_due [$];
    probe_t probes [$];

    int          n_samples;
    int          n_drives;
    int          n_errors;
    int          n_settings;
    int          burst_left;
    logic [31:0] clock_ms;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        #(TIMEOUT_NS);
        $display("grow_climate_actuator_controller_test: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // shadow model of the four actuators
    // ---------------------------------------------------------------

    // apply one sample to the shadow state, return the drive word it yields
    function automatic drive_t advance_climate(sample_t s);
        int hour;
        int win_lo;
        int win_hi;
        int air;
        int soil;
        int hum;
        int ideal_air;
        int ideal_soil;
        int ideal_hum;
        int band;
        bit can;
        bit want;
        bit enough;
        bit hot;
        bit cold;
        bit humid;
        bit turn_off;
        bit turn_on;

        // pump: the run time or wet soil stops it, no hold-off on stopping
        can      = (s.now_ms - toggled_at[ACT_PUMP]) >= PUMP_HOLD_MS;
        want     = s.soil_moisture < settings.water_limit;
        turn_off = actuators_on.pump &&
                   (((s.now_ms - pump_started) >= settings.watering_ms) || !want);
        turn_on  = !actuators_on.pump && want && can;
        if (turn_off || turn_on)
        begin
            actuators_on.pump    = !actuators_on.pump;
            toggled_at[ACT_PUMP] = s.now_ms;
            if (turn_on)
                pump_started = s.now_ms;
        end

        // light: window centered on noon, start may go below zero
        can      = (s.now_ms - toggled_at[ACT_LIGHT]) >= LIGHT_HOLD_MS;
        enough   = s.light_lux > settings.lux_thresh;
        hour     = s.hour_of_day;
        win_hi   = settings.sunny_hours;
        win_lo   = LIGHT_NOON - win_hi / 2;
        win_hi   = win_lo + win_hi;
        want     = (hour >= win_lo) && (hour < win_hi);
        turn_off = actuators_on.light && ((enough && can) || !want);
        turn_on  = !actuators_on.light && !enough && want && can;
        if (turn_off || turn_on)
        begin
            actuators_on.light    = !actuators_on.light;
            toggled_at[ACT_LIGHT] = s.now_ms;
        end

        // fan: heat or humidity starts it, cool and dry air stops it
        can       = (s.now_ms - toggled_at[ACT_FAN]) >= FAN_HOLD_MS;
        air       = $signed(s.air_temp);
        ideal_air = $signed(settings.ideal_air_temp);
        band      = settings.temp_band;
        hum       = s.air_humidity;
        ideal_hum = settings.ideal_humidity;
        hot       = air > ideal_air + band;
        cold      = air < ideal_air - band;
        humid     = hum > ideal_hum + HUMIDITY_BAND;
        turn_off  = actuators_on.fan && cold && (hum <= ideal_hum) && can;
        turn_on   = !actuators_on.fan && (hot || humid) && can;
        if (turn_off || turn_on)
        begin
            actuators_on.fan    = !actuators_on.fan;
            toggled_at[ACT_FAN] = s.now_ms;
        end

        // heating pad: plain two-sided band around the soil target
        can        = (s.now_ms - toggled_at[ACT_PAD]) >= PAD_HOLD_MS;
        soil       = $signed(s.soil_temp);
        ideal_soil = $signed(settings.ideal_soil_temp);
        cold       = soil < ideal_soil - band;
        hot        = soil > ideal_soil + band;
        turn_off   = actuators_on.pad && hot && can;
        turn_on    = !actuators_on.pad && cold && can;
        if (turn_off || turn_on)
        begin
            actuators_on.pad    = !actuators_on.pad;
            toggled_at[ACT_PAD] = s.now_ms;
        end

        return actuators_on;
    endfunction

    // mirror one accepted register write; unknown indexes fall through
    function automatic void note_register(logic [3:0] idx, logic [15:0] data);
        case (idx)
            REG_WATER_LIMIT:     settings.water_limit     = data[6:0];
            REG_WATERING_MS:     settings.watering_ms     = data;
            REG_SUNNY_HOURS:     settings.sunny_hours     = data[4:0];
            REG_LUX_THRESH:      settings.lux_thresh      = data;
            REG_IDEAL_AIR_TEMP:  settings.ideal_air_temp  = data[10:0];
            REG_IDEAL_HUMIDITY:  settings.ideal_humidity  = data[9:0];
            REG_IDEAL_SOIL_TEMP: settings.ideal_soil_temp = data[10:0];
            REG_TEMP_BAND:       settings.temp_band       = data[7:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic sample_t pack_sample(logic [31:0] now, int hour, int moist, int lux,
                                            int air, int hum, int soil);
        sample_t s;
        s.now_ms        = now;
        s.hour_of_day   = 5'(hour);
        s.soil_moisture = 7'(moist);
        s.light_lux     = 16'(lux);
        s.air_temp      = 11'(air);
        s.air_humidity  = 10'(hum);
        s.soil_temp     = 11'(soil);
        return s;
    endfunction

    function automatic void add_probe(logic [31:0] now, int hour, int moist, int lux,
                                      int air, int hum, int soil, bit typed, drive_t want);
        probe_t p;
        p.smp   = pack_sample(now, hour, moist, lux, air, hum, soil);
        p.typed = typed;
        p.want  = want;
        probes.push_back(p);
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int jitter(int center, int spread);
        return center + int'($urandom_range(2 * spread, 0)) - spread;
    endfunction

    // roughly one field in eight gets raw bits, out of range included
    function automatic bit wild();
        return $urandom_range(7, 0) == 0;
    endfunction

    // random register word: the meaningful bits plus junk above them
    function automatic logic [15:0] with_junk(logic [15:0] value, int width);
        logic [15:0] keep;
        keep = 16'hFFFF >> (16 - width);
        return (16'($urandom) & ~keep) | (value & keep);
    endfunction

    // random sample, mostly steered to the current thresholds
    function automatic sample_t draw_sample();
        sample_t s;
        int      pick;
        int      edge_val;

        // timestamp walks forward in small and hold-off sized steps, stays put or jumps anywhere
        pick = $urandom_range(99, 0);
        if (pick < 45)
            clock_ms += $urandom_range(2500, 0);
        else if (pick < 88)
            clock_ms += $urandom_range(70000, 2500);
        else if (pick >= 95)
            clock_ms = $urandom;
        s.now_ms = clock_ms;

        if ($urandom_range(9, 0) == 0)
            s.hour_of_day = 5'($urandom_range(31, 24));
        else
            s.hour_of_day = 5'($urandom_range(23, 0));

        if (wild())
            s.soil_moisture = 7'($urandom);
        else if ($urandom_range(1, 0) == 1)
            s.soil_moisture = 7'(clamp(jitter(settings.water_limit, 2), 0, 127));
        else
            s.soil_moisture = 7'($urandom_range(100, 0));

        if (wild())
            s.light_lux = 16'($urandom);
        else
            s.light_lux = 16'(clamp(jitter(settings.lux_thresh, 2), 0, 65535));

        // temperatures land next to one edge of the band
        if (wild())
            s.air_temp = 11'($urandom);
        else
        begin
            edge_val = $urandom_range(1, 0) ?
                       $signed(settings.ideal_air_temp) + int'(settings.temp_band) :
                       $signed(settings.ideal_air_temp) - int'(settings.temp_band);
            s.air_temp = 11'(clamp(jitter(edge_val, 2), -1024, 1023));
        end

        if (wild())
            s.air_humidity = 10'($urandom);
        else
        begin
            edge_val = $urandom_range(1, 0) ? int'(settings.ideal_humidity) :
                       int'(settings.ideal_humidity) + HUMIDITY_BAND;
            s.air_humidity = 10'(clamp(jitter(edge_val, 2), 0, 1023));
        end

        if (wild())
            s.soil_temp = 11'($urandom);
        else
        begin
            edge_val = $urandom_range(1, 0) ?
                       $signed(settings.ideal_soil_temp) + int'(settings.temp_band) :
                       $signed(settings.ideal_soil_temp) - int'(settings.temp_band);
            s.soil_temp = 11'(clamp(jitter(edge_val, 2), -1024, 1023));
        end
        return s;
    endfunction

    // hand one sample word to the block in bursts with random gaps
    task automatic offer_sample(input sample_t s, input bit typed, input drive_t want);
        drive_t predicted;
        if (burst_left == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge clk);
            // now and then a long run with no idling at all
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(120, 40) :
                         $urandom_range(12, 1);
        end
        burst_left--;
        sample_ch.valid         <= 1'b1;
        sample_ch.now_ms        <= s.now_ms;
        sample_ch.hour_of_day   <= s.hour_of_day;
        sample_ch.soil_moisture <= s.soil_moisture;
        sample_ch.light_lux     <= s.light_lux;
        sample_ch.air_temp      <= s.air_temp;
        sample_ch.air_humidity  <= s.air_humidity;
        sample_ch.soil_temp     <= s.soil_temp;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predicted = advance_climate(s);
        drives_due.push_back(typed ? want : predicted);
        n_samples++;
    endtask

    // stop sending and let every pending word come out of the pipe
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (drives_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [3:0] idx, input logic [15:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        note_register(idx, data);
    endtask

    // reprogram every register while the block is idle
    task automatic apply_settings(input setting_kind_t kind);
        cfg_t target;
        settle();
        case (kind)
            SET_DEFAULT:
                target = '{water_limit: RST_WATER_LIMIT, watering_ms: RST_WATERING_MS,
                           sunny_hours: RST_SUNNY_HOURS, lux_thresh: RST_LUX_THRESH,
                           ideal_air_temp: RST_IDEAL_AIR_TEMP,
                           ideal_humidity: RST_IDEAL_HUMIDITY,
                           ideal_soil_temp: RST_IDEAL_SOIL_TEMP, temp_band: RST_TEMP_BAND};
            // everything at the bottom: no watering wanted, never sunny
            SET_LOW:
                target = '{water_limit: 7'd0, watering_ms: 16'd0, sunny_hours: 5'd0,
                           lux_thresh: 16'd0, ideal_air_temp: -11'sd1024,
                           ideal_humidity: 10'd0, ideal_soil_temp: -11'sd1024,
                           temp_band: 8'd0};
            // everything at the top: window start falls below midnight
            SET_HIGH:
                target = '{water_limit: 7'd127, watering_ms: 16'hFFFF, sunny_hours: 5'd31,
                           lux_thresh: 16'hFFFF, ideal_air_temp: 11'sd1023,
                           ideal_humidity: 10'd1023, ideal_soil_temp: 11'sd1023,
                           temp_band: 8'd255};
            default:
            begin
                target.water_limit     = ($urandom_range(9, 0) == 0) ?
                                         7'($urandom) : 7'($urandom_range(100, 0));
                target.watering_ms     = ($urandom_range(4, 0) == 0) ?
                                         16'($urandom) : 16'($urandom_range(6000, 0));
                target.sunny_hours     = ($urandom_range(6, 0) == 0) ?
                                         5'($urandom_range(31, 25)) :
                                         5'($urandom_range(24, 0));
                target.lux_thresh      = 16'($urandom);
                target.ideal_air_temp  = 11'(int'($urandom_range(1250, 0)) - 400);
                target.ideal_humidity  = 10'($urandom_range(1000, 0));
                target.ideal_soil_temp = 11'(int'($urandom_range(1250, 0)) - 400);
                target.temp_band       = ($urandom_range(3, 0) == 0) ?
                                         8'($urandom) : 8'($urandom_range(60, 0));
            end
        endcase
        write_register(REG_WATER_LIMIT,     with_junk(16'(target.water_limit), 7));
        write_register(REG_WATERING_MS,     target.watering_ms);
        write_register(REG_SUNNY_HOURS,     with_junk(16'(target.sunny_hours), 5));
        write_register(REG_LUX_THRESH,      target.lux_thresh);
        write_register(REG_IDEAL_AIR_TEMP,  with_junk(16'(target.ideal_air_temp), 11));
        write_register(REG_IDEAL_HUMIDITY,  with_junk(16'(target.ideal_humidity), 10));
        write_register(REG_IDEAL_SOIL_TEMP, with_junk(16'(target.ideal_soil_temp), 11));
        write_register(REG_TEMP_BAND,       with_junk(16'(target.temp_band), 8));
        // a write to an index nobody decodes must leave all settings alone
        write_register(4'($urandom_range(15, REG_SPARE_LO)), 16'($urandom));
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // ---------------------------------------------------------------
    // result side: stall pattern and checker
    // ---------------------------------------------------------------

    // ready follows its own pattern: open stretches, coin flips, long stalls
    initial
    begin
        sink_mode_t mode;
        int         mode_left;
        mode      = TAKE_ALL;
        mode_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(2, 0));
                mode_left = $urandom_range(60, 5);
            end
            mode_left--;
            case (mode)
                TAKE_ALL:  result_ch.ready <= 1'b1;
                TAKE_HALF: result_ch.ready <= 1'($urandom_range(1, 0));
                default:   result_ch.ready <= ($urandom_range(7, 0) == 0);
            endcase
        end
    end

    task automatic compare_flag(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            n_errors++;
            // keep the log short when the block is badly off
            if (n_errors <= MAX_REPORTS)
                $error("%s: expected %0b, actual %0b", name, want, got);
        end
    endtask

    // each accepted drive word is checked against the oldest one owed
    always @(posedge clk)
    begin
        drive_t due;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            n_drives++;
            if (drives_due.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $error("drive word arrived with no sample pending");
            end
            else
            begin
                due = drives_due.pop_front();
                compare_flag("pump_drive",  due.pump,  result_ch.pump_drive);
                compare_flag("light_drive", due.light, result_ch.light_drive);
                compare_flag("fan_drive",   due.fan,   result_ch.fan_drive);
                compare_flag("pad_drive",   due.pad,   result_ch.pad_drive);
            end
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        sample_t s;

        // every input known from time zero
        rst_n                   <= 1'b0;
        sample_ch.valid         <= 1'b0;
        sample_ch.now_ms        <= '0;
        sample_ch.hour_of_day   <= '0;
        sample_ch.soil_moisture <= '0;
        sample_ch.light_lux     <= '0;
        sample_ch.air_temp      <= '0;
        sample_ch.air_humidity  <= '0;
        sample_ch.soil_temp     <= '0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= '0;
        cfg_ch.data             <= '0;

        settings = '{water_limit: RST_WATER_LIMIT, watering_ms: RST_WATERING_MS,
                     sunny_hours: RST_SUNNY_HOURS, lux_thresh: RST_LUX_THRESH,
                     ideal_air_temp: RST_IDEAL_AIR_TEMP, ideal_humidity: RST_IDEAL_HUMIDITY,
                     ideal_soil_temp: RST_IDEAL_SOIL_TEMP, temp_band: RST_TEMP_BAND};
        actuators_on = '0;
        pump_started = '0;
        foreach (toggled_at[i])
            toggled_at[i] = '0;
        n_samples  = 0;
        n_drives   = 0;
        n_errors   = 0;
        n_settings = 0;
        burst_left = 0;

        // directed samples under the reset settings: window 6..17 h,
        // air 20..24 C, soil 18..22 C, humidity 60/65 %, water below 30 %
        // all last-toggle stamps are zero, so nothing moves before 60 s
        add_probe(32'd0,     0,  0,   0,     -1024, 0,    -1024, 1'b1, 4'b0000);
        add_probe(32'd59999, 12, 127, 65535, 1023,  1023, 1023,  1'b1, 4'b0000);
        // hold-off just expired and every on rule fires at once
        add_probe(32'd60000, 12, 0,   0,     1023,  1023, -1024, 1'b1, 4'b1111);
        // wet soil stops the pump with no hold-off
        add_probe(32'd60001, 12, 100, 65535, -400,  0,    850,   1'b0, '0);
        // dark hour turns the light off regardless of hold-off
        add_probe(32'd60500, 5,  0,   0,     220,   600,  200,   1'b0, '0);
        // hour past midnight range, cold dry air, hot soil
        add_probe(32'd121000, 31, 127, 0,    -1024, 0,    1023,  1'b0, '0);
        // thresholds hit exactly: equal is not beyond
        add_probe(32'd121001, 24, 29,  1000, 240,   650,  180,   1'b0, '0);
        // pump run time used up, one past every threshold
        add_probe(32'd123001, 6,  29,  1000, 241,   651,  179,   1'b0, '0);
        add_probe(32'd200000, 17, 30,  1001, 850,   1000, -400,  1'b0, '0);
        // timestamp wraps through zero
        add_probe(32'hFFFF_FFFF, 18, 100, 0,     -400, 1000, 850,   1'b0, '0);
        add_probe(32'h0000_0010, 23, 0,   65535, 199,  600,  221,   1'b0, '0);
        add_probe(32'h0000_EA80, 12, 0,   0,     1023, 1023, -1024, 1'b0, '0);
        add_probe(32'h8000_0000, 0,  127, 65535, 1023, 1023, -1024, 1'b0, '0);
        add_probe(32'h8000_EA60, 11, 0,   0,     -1024, 0,   1023,  1'b0, '0);
        // bit patterns across every field
        add_probe(32'hFFFF_FFFE, 12, 64,  32768, -1,   512,  -1,    1'b0, '0);
        add_probe(32'h5555_5555, 21, 85,  21845, 341,  341,  -342,  1'b0, '0);
        add_probe(32'hAAAA_AAAA, 10, 42,  43690, -683, 682,  682,   1'b0, '0);
        add_probe(32'hAAAB_6000, 30, 127, 65535, 1023, 1023, 1023,  1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
            offer_sample(probes[i].smp, probes[i].typed, probes[i].want);
        clock_ms = probes[probes.size() - 1].smp.now_ms;

        // random phases, each under a fresh set of registers
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                1:       apply_settings(SET_LOW);
                3:       apply_settings(SET_HIGH);
                5:       apply_settings(SET_DEFAULT);
                default: apply_settings(SET_RANDOM);
            endcase
            repeat (SAMPLES_PER_SET)
            begin
                s = draw_sample();
                offer_sample(s, 1'b0, '0);
            end
        end

        settle();
        $display("run covered %0d samples and %0d drive words under %0d register settings,",
                 n_samples, n_drives, n_settings);
        $display("with timestamp wrap, late hours, raw out-of-range readings and both stalls");
        if (n_errors == 0)
            $display("grow_climate_actuator_controller_test: PASS");
        else
            $display("grow_climate_actuator_controller_test: FAIL");
        $finish;
    end

endmodule
